### src/aes_iks_pkg.sv
// Shared types, constants and tables for the AES-128 inverse key schedule.
package aes_iks_pkg;

  localparam int unsigned ROUNDS_W = 4;
  localparam int unsigned HALF_W   = 64;
  localparam int unsigned WORD_W   = 32;

  // Controller to datapath command
  typedef struct packed {
    logic                load;
    logic                step;
    logic [ROUNDS_W-1:0] idx;   // backward step number, counts down to 1
  } aes_iks_cmd_t;

  // Forward AES S-box
  localparam logic [7:0] SBOX_TAB [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  // Round constant for backward step number idx (1 to 10)
  function automatic logic [7:0] rcon(input logic [ROUNDS_W-1:0] idx);
    logic [7:0] r;
    case (idx)
      4'd1:    r = 8'h01;
      4'd2:    r = 8'h02;
      4'd3:    r = 8'h04;
      4'd4:    r = 8'h08;
      4'd5:    r = 8'h10;
      4'd6:    r = 8'h20;
      4'd7:    r = 8'h40;
      4'd8:    r = 8'h80;
      4'd9:    r = 8'h1b;
      4'd10:   r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // S-box applied to each byte of a word
  function automatic logic [WORD_W-1:0] sub_word(input logic [WORD_W-1:0] w);
    return {SBOX_TAB[w[31:24]], SBOX_TAB[w[23:16]], SBOX_TAB[w[15:8]], SBOX_TAB[w[7:0]]};
  endfunction

endpackage

### src/aes_iks_datapath.sv
// Key register and one backward key expansion step per cycle while cmd_i.step is set.
module aes_iks_datapath import aes_iks_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  aes_iks_cmd_t      cmd_i,
  input  logic [HALF_W-1:0] key_hi_i,
  input  logic [HALF_W-1:0] key_lo_i,
  output logic [HALF_W-1:0] key_hi_o,
  output logic [HALF_W-1:0] key_lo_o
);

  logic [HALF_W-1:0] hi_q, hi_d, lo_q, lo_d;
  logic [WORD_W-1:0] w0, w1, w2, w3, p0, p1, p2, p3, rot;

  // Backward step: words 3..1 from neighbours, word 0 through the S-box
  always_comb begin
    w0  = hi_q[63:32];
    w1  = hi_q[31:0];
    w2  = lo_q[63:32];
    w3  = lo_q[31:0];
    p3  = w3 ^ w2;
    p2  = w2 ^ w1;
    p1  = w1 ^ w0;
    rot = {p3[23:0], p3[31:24]};
    p0  = w0 ^ sub_word(rot) ^ {rcon(cmd_i.idx), 24'h000000};
  end

  // Next key: load a new item, take a step or hold
  always_comb begin
    hi_d = hi_q;
    lo_d = lo_q;
    if (cmd_i.load) begin
      hi_d = key_hi_i;
      lo_d = key_lo_i;
    end else if (cmd_i.step) begin
      hi_d = {p0, p1};
      lo_d = {p2, p3};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_q <= '0;
      lo_q <= '0;
    end else begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  assign key_hi_o = hi_q;
  assign key_lo_o = lo_q;

endmodule

### src/aes_iks_ctrl.sv
// Sequencer: loads an item, counts backward steps, presents the result.
module aes_iks_ctrl import aes_iks_pkg::*; #(
  parameter int unsigned MAX_ROUNDS = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [ROUNDS_W-1:0] rounds_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output aes_iks_cmd_t        cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  localparam logic [ROUNDS_W-1:0] MaxRnd = ROUNDS_W'(MAX_ROUNDS);

  state_e              state_q, state_d;
  logic [ROUNDS_W-1:0] cnt_q, cnt_d, rnd_sat;
  logic                accept;

  // Counts above the maximum act as the maximum
  assign rnd_sat = (rounds_i > MaxRnd) ? MaxRnd : rounds_i;

  // A new item may enter when idle or while the previous result is taken
  assign in_stall_o  = !((state_q == ST_IDLE) || ((state_q == ST_DONE) && !out_stall_i));
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == ST_DONE);

  assign cmd_o.load = accept;
  assign cmd_o.step = (state_q == ST_RUN);
  assign cmd_o.idx  = cnt_q;

  // Next state and step count
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE, ST_DONE: begin
        if (accept) begin
          cnt_d   = rnd_sat;
          state_d = (rnd_sat == '0) ? ST_DONE : ST_RUN;
        end else if (state_q == ST_DONE && !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      ST_RUN: begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == ROUNDS_W'(1)) begin
          state_d = ST_DONE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

### src/aes128_inverse_key_schedule.sv
// An accepted item is loaded, then stepped back once for each count from rounds down to 1;
// a count of zero goes straight to the result. No item is taken while steps run; the next
// item is taken in the cycle its predecessor's result leaves.
// One shared step unit handles one backward round per cycle, indexed by a down counter.
// Reset (rst_ni low, asynchronous) clears the key register, counter and sequencer.
module aes128_inverse_key_schedule import aes_iks_pkg::*; #(
  parameter int unsigned MAX_ROUNDS = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [HALF_W-1:0]   key_hi_i,
  input  logic [HALF_W-1:0]   key_lo_i,
  input  logic [ROUNDS_W-1:0] rounds_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [HALF_W-1:0]   cipher_key_hi_o,
  output logic [HALF_W-1:0]   cipher_key_lo_o
);

  aes_iks_cmd_t cmd;

  aes_iks_ctrl #(
    .MAX_ROUNDS (MAX_ROUNDS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rounds_i    (rounds_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  aes_iks_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .key_hi_i (key_hi_i),
    .key_lo_i (key_lo_i),
    .key_hi_o (cipher_key_hi_o),
    .key_lo_o (cipher_key_lo_o)
  );

endmodule
